### sv/cnms_pkg.sv
// ----------------------------------------------------------------------------
// cnms_pkg: shared types and constants for the non-maximum suppression unit
// Pixel and result payload types, register indexes, direction classes and
// the line buffer word layout.
// ----------------------------------------------------------------------------
package cnms_pkg;

  localparam int MAG_W     = 8;
  localparam int GRAD_W    = 16;
  localparam int CFG_W     = 13;
  localparam int OUT_ROW_W = 12;
  localparam int OUT_COL_W = 10;

  localparam logic [MAG_W-1:0] EDGE_STRONG = 8'd255;
  localparam logic [MAG_W-1:0] EDGE_WEAK   = 8'd125;
  localparam logic [MAG_W-1:0] EDGE_NONE   = 8'd0;
  localparam logic [7:0]       CODE_HORZ   = 8'd0;
  localparam logic [7:0]       CODE_VERT   = 8'd90;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_LOW_THR  = 2'd0;
  localparam logic [1:0] REG_HIGH_THR = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  typedef enum logic [1:0] {
    DIR_HORZ     = 2'd0,
    DIR_VERT     = 2'd1,
    DIR_DIAG_POS = 2'd2,
    DIR_DIAG_NEG = 2'd3
  } dir_class_t;

  typedef struct packed {
    logic        [MAG_W-1:0]  grad_magnitude;
    logic signed [7:0]        direction_code;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic                     frame_start;
  } pixel_t;

  typedef struct packed {
    logic [MAG_W-1:0]     edge_value;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
  } result_t;

  // Work item handed from the front to the back (column address travels beside it).
  typedef struct packed {
    logic [MAG_W-1:0]     mag;
    dir_class_t           cls;
    logic                 emit;
    logic                 interior;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
  } work_t;

  typedef struct packed {
    logic [MAG_W-1:0] low;
    logic [MAG_W-1:0] high;
  } thresh_t;

  // One line buffer entry: two rows back, one row back, class of one row back.
  typedef struct packed {
    logic [MAG_W-1:0] top;
    logic [MAG_W-1:0] mid;
    dir_class_t       cls;
  } line_word_t;

endpackage

### sv/cnms_queue.sv
// ----------------------------------------------------------------------------
// cnms_queue: small synchronous FIFO
// Register based queue with full and empty flags, used between the stages.
// ----------------------------------------------------------------------------
module cnms_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### sv/cnms_front.sv
// ----------------------------------------------------------------------------
// cnms_front: pixel intake and classification
// Tracks the raster position, classifies the gradient direction and decides
// whether the pixel one row and one column back is emitted and interior.
// ----------------------------------------------------------------------------
module cnms_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int COL_W      = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  cnms_pkg::pixel_t               pixel,
  output logic                           full,
  input  logic [10:0]                    image_width,
  input  logic [12:0]                    image_height,
  input  logic                           back_busy,
  input  logic                           q_full,
  output logic                           q_push,
  output cnms_pkg::work_t                work,
  output logic [COL_W-1:0]               work_addr
);
  import cnms_pkg::*;

  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WCW   = $clog2(MAX_WIDTH + 1);
  localparam int RCW   = $clog2(MAX_HEIGHT + 1);

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [WCW-1:0]   eff_w;
  logic [RCW-1:0]   eff_h;
  logic [COL_W-1:0] c_base;
  logic [ROW_W-1:0] r_base;
  logic [COL_W-1:0] c_cur;
  logic [ROW_W-1:0] r_cur;
  logic [WCW-1:0]   c_inc;
  logic [RCW-1:0]   r_inc;
  logic             accept;
  logic             gx_neg;
  logic             gy_neg;
  logic             gx_pos;
  logic             gy_pos;
  dir_class_t       cls;

  assign full   = q_full || back_busy;
  assign accept = push && !full;
  assign q_push = accept;

  // Geometry clamped to 1..MAX.
  always_comb begin
    if (image_width == '0) begin
      eff_w = WCW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = WCW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = RCW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = RCW'(MAX_HEIGHT);
    end else begin
      eff_h = RCW'(image_height);
    end
  end

  always_comb begin
    r_base = pixel.frame_start ? '0 : row;
    c_base = pixel.frame_start ? '0 : col;
    r_cur  = (RCW'(r_base) >= eff_h) ? '0 : r_base;
    c_cur  = (WCW'(c_base) >= eff_w) ? '0 : c_base;
    c_inc  = WCW'(c_cur) + WCW'(1);
    r_inc  = RCW'(r_cur) + RCW'(1);
    if (c_inc >= eff_w) begin
      col_next = '0;
      row_next = (r_inc >= eff_h) ? '0 : ROW_W'(r_inc);
    end else begin
      col_next = COL_W'(c_inc);
      row_next = r_cur;
    end
  end

  always_comb begin
    gx_neg = pixel.grad_x[GRAD_W-1];
    gy_neg = pixel.grad_y[GRAD_W-1];
    gx_pos = !gx_neg && (pixel.grad_x != '0);
    gy_pos = !gy_neg && (pixel.grad_y != '0);
    if (pixel.direction_code == CODE_HORZ) begin
      cls = DIR_HORZ;
    end else if (pixel.direction_code == CODE_VERT) begin
      cls = DIR_VERT;
    end else if ((gx_neg && gy_pos) || (gx_pos && gy_neg)) begin
      cls = DIR_DIAG_POS;
    end else begin
      cls = DIR_DIAG_NEG;
    end
  end

  always_comb begin
    work.mag      = pixel.grad_magnitude;
    work.cls      = cls;
    work.emit     = (r_cur != '0) && (c_cur != '0);
    work.interior = (r_cur >= ROW_W'(3)) && (r_inc < eff_h) &&
                    (c_cur >= COL_W'(3)) && (c_inc < eff_w);
    work.out_row  = OUT_ROW_W'(r_cur - ROW_W'(1));
    work.out_col  = OUT_COL_W'(c_cur - COL_W'(1));
    work_addr     = c_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

### sv/cnms_back.sv
// ----------------------------------------------------------------------------
// cnms_back: line buffers, 3x3 window and peak decision
// Two stage pipeline: address stage reads the line buffer, data stage writes
// it back, shifts the window and judges the centre pixel.
// ----------------------------------------------------------------------------
module cnms_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int COL_W     = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cnms_pkg::thresh_t    thresh,
  input  logic                 q_empty,
  input  cnms_pkg::work_t      work,
  input  logic [COL_W-1:0]     work_addr,
  output logic                 q_pop,
  output logic                 busy,
  input  logic                 res_full,
  output logic                 res_push,
  output cnms_pkg::result_t    res
);
  import cnms_pkg::*;

  line_word_t       lines [MAX_WIDTH];
  line_word_t       rd_word;
  line_word_t       wr_word;
  logic             clearing;
  logic [COL_W-1:0] clr_addr;
  logic             advance;
  logic             fwd;

  logic             a_valid;
  work_t            a_work;
  logic [COL_W-1:0] a_addr;
  logic             b_valid;
  work_t            b_work;
  logic [COL_W-1:0] b_addr;

  logic [MAG_W-1:0] win [3][3];
  dir_class_t       cls_hold;

  logic [MAG_W-1:0] m;
  logic             peak;

  assign busy    = clearing;
  assign advance = !res_full && !clearing;
  assign q_pop   = advance && !q_empty;
  assign fwd     = a_valid && b_valid && (a_addr == b_addr);

  assign wr_word.top = rd_word.mid;
  assign wr_word.mid = b_work.mag;
  assign wr_word.cls = b_work.cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + COL_W'(1);
        if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        a_valid <= !q_empty;
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_work <= work;
      a_addr <= work_addr;
      b_work <= a_work;
      b_addr <= a_addr;
    end
  end

  // Line buffer: read for the address stage, write back from the data stage.
  always_ff @(posedge clk) begin
    if (clearing) begin
      lines[clr_addr] <= '0;
    end else if (advance && b_valid) begin
      lines[b_addr] <= wr_word;
    end
    if (advance) begin
      rd_word <= fwd ? wr_word : lines[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= '0;
        end
      end
      cls_hold <= DIR_HORZ;
    end else if (advance && b_valid) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= rd_word.top;
      win[1][2] <= rd_word.mid;
      win[2][2] <= b_work.mag;
      cls_hold  <= rd_word.cls;
    end
  end

  // The decision looks at the window as it stands after this shift.
  always_comb begin
    m = win[1][2];
    case (cls_hold)
      DIR_HORZ:     peak = (m > win[1][1]) && (m >= rd_word.mid);
      DIR_VERT:     peak = (m > win[0][2]) && (m >= win[2][2]);
      DIR_DIAG_POS: peak = (m >= win[2][1]) && (m > rd_word.top);
      DIR_DIAG_NEG: peak = (m >= b_work.mag) && (m > win[0][1]);
      default:      peak = 1'b0;
    endcase
  end

  always_comb begin
    res.out_row = b_work.out_row;
    res.out_col = b_work.out_col;
    if (b_work.interior && (m > thresh.low) && (m != '0) && peak) begin
      res.edge_value = (m >= thresh.high) ? EDGE_STRONG : EDGE_WEAK;
    end else begin
      res.edge_value = EDGE_NONE;
    end
  end

  assign res_push = advance && b_valid && b_work.emit;

endmodule

### sv/canny_nonmax_suppress_unit.sv
// ----------------------------------------------------------------------------
// canny_nonmax_suppress_unit: Canny non-maximum suppression on a pixel stream
// Raster pixels in, one edge verdict per pixel past row 0 and column 0 out, one row and one pixel late.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake        Payload              Notes
//   pixel     push / full      pixel (pixel_t)      one transaction per pixel
//   result    pop / empty      result (result_t)    none for row 0 or column 0
//   config    cfg_wr_en        cfg_index, cfg_data  write only, no wait
//
// The unit sustains one pixel per clock while results are popped. A pixel
// crosses the intake stage, a four entry work queue, the line buffer address
// and data stages and a two entry result queue before its result is visible.
// The line buffer memory takes one read and one write per cycle, which sets
// that rate. After reset the line buffer is cleared one entry per cycle, all
// MAX_WIDTH entries, during which full is held high; configuration writes are
// taken at any time. A stalled result queue stops the back pipeline, the work
// queue then fills and raises full.
//
module canny_nonmax_suppress_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cnms_pkg::pixel_t      pixel,
  output logic                  full,
  input  logic                  pop,
  output cnms_pkg::result_t     result,
  output logic                  empty,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [12:0]           cfg_data
);
  import cnms_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WORK_W = $bits(work_t) + COL_W;

  // Configuration registers.
  thresh_t     thresh;
  logic [10:0] image_width;
  logic [12:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.low   <= 8'd20;
      thresh.high  <= 8'd50;
      image_width  <= 11'd640;
      image_height <= 13'd480;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOW_THR:  thresh.low   <= cfg_data[7:0];
        REG_HIGH_THR: thresh.high  <= cfg_data[7:0];
        REG_WIDTH:    image_width  <= cfg_data[10:0];
        REG_HEIGHT:   image_height <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Front half: position tracking and classification.
  logic             q_push;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             back_busy;
  work_t            work_in;
  logic [COL_W-1:0] addr_in;
  work_t            work_out;
  logic [COL_W-1:0] addr_out;
  logic [WORK_W-1:0] q_rdata;

  cnms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pixel        (pixel),
    .full         (full),
    .image_width  (image_width),
    .image_height (image_height),
    .back_busy    (back_busy),
    .q_full       (q_full),
    .q_push       (q_push),
    .work         (work_in),
    .work_addr    (addr_in)
  );

  // Work queue lets the intake and the line buffer pipeline stall apart.
  cnms_queue #(
    .DATA_W (WORK_W),
    .DEPTH  (4)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({addr_in, work_in}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign work_out = q_rdata[$bits(work_t)-1:0];
  assign addr_out = q_rdata[WORK_W-1:$bits(work_t)];

  // Back half: line buffers, window and decision.
  logic    res_push;
  logic    res_full;
  result_t res;

  cnms_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .thresh    (thresh),
    .q_empty   (q_empty),
    .work      (work_out),
    .work_addr (addr_out),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Result queue decouples the pipeline from the consumer.
  cnms_queue #(
    .DATA_W ($bits(result_t)),
    .DEPTH  (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

### tb/canny_nonmax_suppress_unit_tb.sv
// ----------------------------------------------------------------------------
// canny_nonmax_suppress_unit_tb: self-checking bench for the suppression unit
// Streams raster pixels under several image geometries and threshold
// settings, predicts every edge verdict in the bench, and checks each
// result transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module canny_nonmax_suppress_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cnms_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 4096;
  // Cycles to let the pipeline settle after the last prediction has been
  // matched. Pixels of row 0 and column 0 give no result, so one of them may
  // still be inside the unit when the last result has been popped.
  localparam int DRAIN_CYCLES   = 32;
  // The line buffer clear after reset alone keeps full high while it walks all
  // MAX_W entries, so the limit on quiet cycles sits well above that clear.
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int MAX_REPORTS    = 10;

  // --------------------------------------------------------------------------
  // Clock, reset and the unit's inputs, all known from time zero.
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  pixel_t      pixel     = '0;
  logic        full;
  logic        pop       = 1'b0;
  result_t     result;
  logic        empty;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_LOW_THR;
  logic [12:0] cfg_data  = '0;

  always #1 clk = ~clk;

  canny_nonmax_suppress_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pixel    (pixel),
    .full     (full),
    .pop      (pop),
    .result   (result),
    .empty    (empty),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the unit's state. The register copies hold the raw written
  // values; the geometry is clamped where it is used, as in the unit.
  // --------------------------------------------------------------------------
  logic [7:0]  thr_low    = 8'd20;
  logic [7:0]  thr_high   = 8'd50;
  logic [10:0] cfg_width  = 11'd640;
  logic [12:0] cfg_height = 13'd480;

  logic [7:0]  mag_row1 [MAX_W] = '{default: '0};   // one row back
  logic [7:0]  mag_row2 [MAX_W] = '{default: '0};   // two rows back
  dir_class_t  dir_row1 [MAX_W] = '{default: DIR_HORZ};
  // Window of magnitudes: first index above / centre / below, second index
  // oldest column to newest column.
  logic [7:0]  win [3][3] = '{default: '0};
  dir_class_t  dir_hold = DIR_HORZ;     // class read one column earlier
  int          next_row = 0;
  int          next_col = 0;

  result_t     expected_edges [$];      // predicted verdicts, oldest first
  pixel_t      pending_pixels [$];      // pixels waiting for the driver
  int          fail_count   = 0;
  int          quiet_cycles = 0;

  function automatic int clamp_dim(int v, int maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Direction class of a pixel. Anything that is not exactly horizontal or
  // vertical goes to a diagonal; the diagonal leans one way only when the two
  // gradients have strictly opposite signs (zero counts as neither sign).
  function automatic dir_class_t classify(logic [7:0] code, logic [15:0] gx,
                                          logic [15:0] gy);
    logic gx_neg, gy_neg, gx_pos, gy_pos;
    if (code == CODE_HORZ) return DIR_HORZ;
    if (code == CODE_VERT) return DIR_VERT;
    gx_neg = gx[15];
    gy_neg = gy[15];
    gx_pos = !gx_neg && (gx != 16'd0);
    gy_pos = !gy_neg && (gy != 16'd0);
    if ((gx_neg && gy_pos) || (gx_pos && gy_neg)) return DIR_DIAG_POS;
    return DIR_DIAG_NEG;
  endfunction

  // Advance the bench state by one accepted pixel and queue the verdict for
  // the pixel one row and one column behind it, if that position exists.
  task automatic suppress_pixel(input pixel_t px);
    int         w, h, r, c, rr, cc;
    logic [7:0] m;
    logic       peak;
    dir_class_t cls_prev;
    result_t    res;
    w = clamp_dim(int'(cfg_width), MAX_W);
    h = clamp_dim(int'(cfg_height), MAX_H);
    if (px.frame_start) begin
      next_row = 0;
      next_col = 0;
    end
    // A smaller geometry written mid-frame folds the position back.
    if (next_row >= h) next_row = 0;
    if (next_col >= w) next_col = 0;
    r = next_row;
    c = next_col;

    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2]   = mag_row2[c];
    win[1][2]   = mag_row1[c];
    win[2][2]   = px.grad_magnitude;
    mag_row2[c] = win[1][2];
    mag_row1[c] = px.grad_magnitude;

    cls_prev    = dir_hold;
    dir_hold    = dir_row1[c];
    dir_row1[c] = classify(px.direction_code, px.grad_x, px.grad_y);

    if (r >= 1 && c >= 1) begin
      rr  = r - 1;
      cc  = c - 1;
      res = '0;
      res.edge_value = EDGE_NONE;
      // Only pixels two or more away from every image edge can be edges.
      if (rr >= 2 && rr + 2 < h && cc >= 2 && cc + 2 < w) begin
        m = win[1][1];
        if (m > thr_low && m != 8'd0) begin
          // One neighbour must be strictly smaller, the other may tie.
          case (cls_prev)
            DIR_HORZ:     peak = (m > win[1][0]) && (m >= win[1][2]);
            DIR_VERT:     peak = (m > win[0][1]) && (m >= win[2][1]);
            DIR_DIAG_POS: peak = (m >= win[2][0]) && (m > win[0][2]);
            default:      peak = (m >= win[2][2]) && (m > win[0][0]);
          endcase
          if (peak) res.edge_value = (m >= thr_high) ? EDGE_STRONG : EDGE_WEAK;
        end
      end
      res.out_row = rr[OUT_ROW_W-1:0];
      res.out_col = cc[OUT_COL_W-1:0];
      expected_edges.push_back(res);
    end

    // Raster advance; the end of the last row wraps to the frame origin even
    // without a frame_start.
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h) next_row = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_grad();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7FFF;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel(int mag_lo, int mag_hi);
    pixel_t px;
    px = '0;
    case ($urandom_range(0, 7))
      0:       px.grad_magnitude = 8'h00;
      1:       px.grad_magnitude = 8'hFF;
      default: px.grad_magnitude = 8'($urandom_range(mag_lo, mag_hi));
    endcase
    case ($urandom_range(0, 3))
      0:       px.direction_code = CODE_HORZ;
      1:       px.direction_code = CODE_VERT;
      default: px.direction_code = 8'($urandom);
    endcase
    px.grad_x = pick_grad();
    px.grad_y = pick_grad();
    return px;
  endfunction

  // One configuration write. The bench copy changes at the edge where the
  // unit takes the write.
  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_LOW_THR:  thr_low    = data[7:0];
      REG_HIGH_THR: thr_high   = data[7:0];
      REG_WIDTH:    cfg_width  = data[10:0];
      REG_HEIGHT:   cfg_height = data[12:0];
      default:      ;
    endcase
  endtask

  // Writes all four registers. Bits above a register's width carry junk,
  // which the unit has to drop.
  task automatic program_regs(int unsigned low, int unsigned high,
                              int unsigned width, int unsigned height);
    logic [12:0] junk;
    junk = 13'($urandom);
    write_reg(REG_LOW_THR,  {junk[12:8], low[7:0]});
    junk = 13'($urandom);
    write_reg(REG_HIGH_THR, {junk[12:8], high[7:0]});
    junk = 13'($urandom);
    write_reg(REG_WIDTH,    {junk[12:11], width[10:0]});
    write_reg(REG_HEIGHT,   height[12:0]);
    cfg_wr_en <= 1'b0;
  endtask

  // Holds the sender back until every queued pixel has gone in and every
  // predicted verdict has come out, then lets the pipeline run dry.
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || push || expected_edges.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A phase: settle, program a setting, then queue a pixel stream. Most
  // phases open with frame_start; some carry on from wherever the previous
  // geometry left the raster position. A rare frame_start mid-stream breaks
  // the frame on purpose.
  task automatic run_phase(int unsigned low, int unsigned high,
                           int unsigned width, int unsigned height,
                           int count, int mag_lo, int mag_hi, bit restart);
    pixel_t px;
    wait_drained();
    program_regs(low, high, width, height);
    for (int i = 0; i < count; i++) begin
      px = random_pixel(mag_lo, mag_hi);
      px.frame_start = (i == 0) ? restart : ($urandom_range(0, 49) == 0);
      pending_pixels.push_back(px);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers pending pixels in bursts of random length with random
  // gaps. A pixel stays on the port until its transaction completes.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) suppress_pixel(pixel);
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          pixel <= pending_pixels.pop_front();
          push  <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pops on a 32-bit pattern that is redrawn each time round,
  // either always ready, half ready, or mostly stalled, and checks every
  // result transaction against the oldest prediction.
  // --------------------------------------------------------------------------
  logic [31:0] pop_pattern = '1;
  int          pat_pos     = 0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_edges.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: edge %0d row %0d col %0d",
                     result.edge_value, result.out_row, result.out_col);
        end else if (result.edge_value !== expected_edges[0].edge_value ||
                     result.out_row    !== expected_edges[0].out_row ||
                     result.out_col    !== expected_edges[0].out_col) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected edge %0d row %0d col %0d, got edge %0d row %0d col %0d",
                     expected_edges[0].edge_value, expected_edges[0].out_row,
                     expected_edges[0].out_col, result.edge_value,
                     result.out_row, result.out_col);
          void'(expected_edges.pop_front());
        end else begin
          void'(expected_edges.pop_front());
        end
      end
      if (pat_pos == 0) begin
        case ($urandom_range(0, 2))
          0:       pop_pattern = '1;
          1:       pop_pattern = $urandom;
          default: pop_pattern = $urandom & $urandom;
        endcase
      end
      pop <= pop_pattern[pat_pos];
      pat_pos = (pat_pos + 1) % 32;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles in which no transaction of either side completes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    pixel_t px;
    int     base, lo, hi;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed frame of 5x5 pixels: only the centre is far enough from the
    // edges to be judged. It is a horizontal peak that beats its left
    // neighbour by one, ties its right neighbour, sits one above the low
    // threshold and exactly on the high one, so it must come out strong.
    // The other pixels sweep the field extremes and give border zeros.
    program_regs(199, 200, 5, 5);
    for (int i = 0; i < 25; i++) begin
      px = '0;
      px.grad_magnitude = (i % 3 == 0) ? 8'hFF : 8'h00;
      case (i % 6)
        0:       px.direction_code = 8'h80;
        1:       px.direction_code = 8'h7F;
        2:       px.direction_code = CODE_VERT;
        3:       px.direction_code = CODE_HORZ;
        4:       px.direction_code = 8'h01;
        default: px.direction_code = 8'hFF;
      endcase
      case (i % 4)
        0:       px.grad_x = 16'h8000;
        1:       px.grad_x = 16'h7FFF;
        2:       px.grad_x = 16'h0000;
        default: px.grad_x = 16'hFFFF;
      endcase
      case (i % 5)
        0:       px.grad_y = 16'h7FFF;
        1:       px.grad_y = 16'h8000;
        2:       px.grad_y = 16'hFFFF;
        3:       px.grad_y = 16'h0000;
        default: px.grad_y = 16'h0001;
      endcase
      px.frame_start = (i == 0);
      if (i == 11) px.grad_magnitude = 8'd199;
      if (i == 12) begin
        px.grad_magnitude = 8'd200;
        px.direction_code = CODE_HORZ;
      end
      if (i == 13) px.grad_magnitude = 8'd200;
      pending_pixels.push_back(px);
    end

    // Threshold extremes on the smallest image, running through several
    // frames that wrap without a frame_start.
    run_phase(0,   0,   5,    5,    80,  0, 255, 1'b1);
    run_phase(255, 255, 6,    5,    60,  0, 255, 1'b1);
    run_phase(254, 255, 7,    6,    60,  0, 255, 1'b0);
    // Zero width and zero height clamp to one: no pixel is ever emitted.
    run_phase(20,  50,  0,    5,    30,  0, 255, 1'b1);
    run_phase(20,  50,  9,    0,    30,  0, 255, 1'b0);
    // All-ones geometry clamps to the maximum; only row 0 is reached.
    run_phase($urandom_range(0, 255), $urandom_range(0, 255), 2047, 8191,
              60, 0, 255, 1'b1);
    // Tallest image, narrow rows.
    run_phase($urandom_range(0, 80), $urandom_range(40, 200), 40, 4096,
              200, 0, 255, 1'b1);

    // Random small geometries. Every other phase squeezes the magnitudes
    // into a narrow band around the thresholds so that ties are common.
    for (int p = 0; p < 10; p++) begin
      if (p % 2 == 0) begin
        lo = $urandom_range(0, 100);
        run_phase(lo, $urandom_range(lo, 255), $urandom_range(5, 16),
                  $urandom_range(5, 12), $urandom_range(40, 80), 0, 255,
                  $urandom_range(0, 3) != 0);
      end else begin
        base = $urandom_range(1, 250);
        hi   = base + 4;
        run_phase(base - 1 + $urandom_range(0, 2), base + $urandom_range(0, 4),
                  $urandom_range(5, 16), $urandom_range(5, 12),
                  $urandom_range(40, 80), base, hi, $urandom_range(0, 3) != 0);
      end
    end

    wait_drained();
    if (fail_count == 0 && expected_edges.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
sv/cnms_pkg.sv
sv/cnms_queue.sv
sv/cnms_front.sv
sv/cnms_back.sv
sv/canny_nonmax_suppress_unit.sv
tb/canny_nonmax_suppress_unit_tb.sv
